// ===== rtl/core/ibcrc_pkg.sv =====
// Shared types, constants and CRC functions for the inverted byte CRC-16 unit.
package ibcrc_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0]  CrcPolyLow = 16'h8005;
  localparam logic [CrcWidth-1:0]  CrcInit    = 16'h0000;
  localparam logic [ByteWidth-1:0] ByteInvert = 8'hFF;

  // Control fields of the word held in the input register.
  typedef struct packed {
    logic valid;
    logic first_byte;
    logic last_byte;
  } stage_ctl_t;

  // Shifts one byte into the remainder, least-significant bit first.
  function automatic logic [CrcWidth-1:0] crc_absorb_byte(
    input logic [CrcWidth-1:0]  rem,
    input logic [ByteWidth-1:0] data
  );
    logic [CrcWidth-1:0] reg_v;
    logic                fb;
    reg_v = rem;
    for (int k = 0; k < ByteWidth; k++) begin
      fb    = reg_v[CrcWidth-1] ^ data[k];
      reg_v = {reg_v[CrcWidth-2:0], 1'b0};
      if (fb) begin
        reg_v = reg_v ^ CrcPolyLow;
      end
    end
    return reg_v;
  endfunction

  // Reverses the bit order of a remainder.
  function automatic logic [CrcWidth-1:0] crc_reverse(input logic [CrcWidth-1:0] v);
    logic [CrcWidth-1:0] res;
    for (int k = 0; k < CrcWidth; k++) begin
      res[CrcWidth-1-k] = v[k];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ibcrc_if.sv =====
// Valid/ready channel interfaces for the input bytes and the CRC results.
interface ibcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface ibcrc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== rtl/core/inverted_byte_crc16_unit.sv =====
// A word accepted with last_byte set shows its CRC once it has passed the input register and then the result register.
// Throughput: one byte word per cycle; the byte-wide CRC update is one XOR network.
// A result left waiting only stalls input once a second last word reaches the input register.
// Reset (rst_n low, synchronous) clears both valid flags and zeroes the running remainder.
// Top level of the CRC-16/ARC unit over bit-inverted payload bytes.
module inverted_byte_crc16_unit (
  input  logic         clk,
  input  logic         rst_n,
  ibcrc_in_if.sink     in_ch,
  ibcrc_out_if.source  out_ch
);
  import ibcrc_pkg::*;

  // Control of the word sitting in the input register, and its byte.
  stage_ctl_t           stage_ctl;
  logic [ByteWidth-1:0] stage_data;
  // High when the held word is absorbed into the remainder this cycle.
  logic                 stage_adv;

  // The input register takes a new word whenever it is empty or its
  // current word is being consumed, so bytes can arrive every cycle.
  ibcrc_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (stage_adv),
    .ctl   (stage_ctl),
    .data  (stage_data)
  );

  // The update stage inverts the byte, folds it into the remainder
  // (cleared first on a start mark) and, on the last byte, loads the
  // bit-reversed remainder into the result register and clears the
  // remainder for the next message. The result register decouples the
  // output handshake from the input side.
  ibcrc_update u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (stage_ctl),
    .data   (stage_data),
    .adv    (stage_adv),
    .out_ch (out_ch)
  );
endmodule

// ===== rtl/core/ibcrc_in_reg.sv =====
// Input register stage: captures one byte word and its framing marks.
module ibcrc_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  ibcrc_in_if.sink              in_ch,
  input  logic                  adv,
  output ibcrc_pkg::stage_ctl_t ctl,
  output logic [7:0]            data
);
  import ibcrc_pkg::*;

  stage_ctl_t           ctl_r, ctl_nxt;
  logic [ByteWidth-1:0] data_r;
  logic                 take;

  // The register frees up in the same cycle its word moves on.
  assign in_ch.ready = !ctl_r.valid || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    ctl_nxt = ctl_r;
    if (take) begin
      ctl_nxt.valid      = 1'b1;
      ctl_nxt.first_byte = in_ch.first_byte;
      ctl_nxt.last_byte  = in_ch.last_byte;
    end else if (adv) begin
      ctl_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.data_byte;
    end
  end

  assign ctl  = ctl_r;
  assign data = data_r;
endmodule

// ===== rtl/core/ibcrc_update.sv =====
// Remainder update and result register for the inverted byte CRC-16.
module ibcrc_update (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ibcrc_pkg::stage_ctl_t ctl,
  input  logic [7:0]            data,
  output logic                  adv,
  ibcrc_out_if.source           out_ch
);
  import ibcrc_pkg::*;

  logic [CrcWidth-1:0] rem_r, rem_nxt;
  logic [CrcWidth-1:0] crc_r;
  logic                out_valid_r, out_valid_nxt;
  logic [CrcWidth-1:0] rem_start;
  logic [CrcWidth-1:0] rem_new;
  logic                emit;

  // A word without the last mark never waits; a last word needs a free result slot.
  assign adv  = ctl.valid && (!ctl.last_byte || !out_valid_r || out_ch.ready);
  assign emit = adv && ctl.last_byte;

  assign rem_start = ctl.first_byte ? CrcInit : rem_r;
  assign rem_new   = crc_absorb_byte(rem_start, data ^ ByteInvert);

  always_comb begin
    rem_nxt = rem_r;
    if (adv) begin
      rem_nxt = ctl.last_byte ? CrcInit : rem_new;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= CrcInit;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      crc_r <= crc_reverse(rem_new);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.crc_value = crc_r;
endmodule
